>>> rtl/bmrp_pkg.sv
// shared types and constants for the bidirectional motor ramp pwm block
// no dependencies

package bmrp_pkg;

    localparam int unsigned LevelW = 8;
    localparam int unsigned KindW  = 2;
    localparam int unsigned DirW   = 2;
    localparam int unsigned SlotW  = 2;
    localparam int unsigned CfgIdxW = 1;

    localparam logic [LevelW-1:0] LevelNeutral  = 8'd127;
    localparam logic [LevelW-1:0] LevelBackBase = 8'd128;
    localparam logic [LevelW-1:0] DutyReset     = 8'd255;
    localparam logic [LevelW-1:0] DwellLimitRst = 8'd50;
    localparam logic [LevelW-1:0] StopByteRst   = 8'd32;

    // item kinds
    localparam logic [KindW-1:0] KIND_TICK   = 2'd0;
    localparam logic [KindW-1:0] KIND_SAMPLE = 2'd1;
    localparam logic [KindW-1:0] KIND_RX     = 2'd2;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_DWELL_LIMIT = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_STOP_BYTE   = 1'd1;

    // direction codes
    localparam logic [DirW-1:0] DRIVE_OFF = 2'd0;
    localparam logic [DirW-1:0] DRIVE_FWD = 2'd1;
    localparam logic [DirW-1:0] DRIVE_REV = 2'd2;

    // adc channel sequence slots
    localparam logic [SlotW-1:0] SLOT_FIRST  = 2'd0;
    localparam logic [SlotW-1:0] SLOT_TARGET = 2'd1;
    localparam logic [SlotW-1:0] SLOT_LAST   = 2'd2;

    typedef struct packed {
        logic [LevelW-1:0] duty;
        logic [DirW-1:0]   direction;
        logic              stopped;
        logic [LevelW-1:0] speed_level;
    } t_result;

endpackage

>>> rtl/bidirectional_motor_ramp_pwm.sv
// top level of the bidirectional motor ramp pwm block
// depends on bmrp_pkg

// Slew-limited bidirectional motor PWM. Every accepted item (tick, ADC sample
// or received byte) is handled combinationally: the controller state updates
// at the accepting edge and one result, showing the state after the item,
// enters a two-entry output queue behind any waiting result. One item is taken
// every cycle; the input stalls only when both queue entries hold results
// that the downstream side has not yet taken. Only the ADC sample in the
// second slot of the rotating three-slot sequence becomes the speed target.
// A received byte equal to stop_byte latches an emergency stop that only
// reset clears. Each tick steps the level by one toward the target, holding
// at neutral 127 for dwell_limit+1 ticks before crossing; with dwell_limit at
// 255 the level never leaves neutral. Configuration writes are always taken
// and should only be issued while no transfer is outstanding.

module bidirectional_motor_ramp_pwm (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input item channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [bmrp_pkg::KindW-1:0]         i_kind,
    input  logic [bmrp_pkg::LevelW-1:0]        i_sample,
    input  logic [bmrp_pkg::LevelW-1:0]        i_rx_byte,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [bmrp_pkg::LevelW-1:0]        o_duty,
    output logic [bmrp_pkg::DirW-1:0]          o_direction,
    output logic                               o_stopped,
    output logic [bmrp_pkg::LevelW-1:0]        o_speed_level,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bmrp_pkg::CfgIdxW-1:0]       i_cfg_index,
    input  logic [bmrp_pkg::LevelW-1:0]        i_cfg_data
);
    import bmrp_pkg::*;

    // configuration registers
    logic [LevelW-1:0] r_dwell_limit;
    logic [LevelW-1:0] r_stop_byte;

    // controller state
    logic [LevelW-1:0] r_ramp_level, n_ramp_level;
    logic [LevelW-1:0] r_target_level, n_target_level;
    logic [SlotW-1:0]  r_slot, n_slot;
    logic [LevelW-1:0] r_dwell_count, n_dwell_count;
    logic              r_at_neutral, n_at_neutral;
    logic              r_stop_latch, n_stop_latch;
    logic [LevelW-1:0] r_duty, n_duty;
    logic [DirW-1:0]   r_direction, n_direction;

    // output queue
    t_result           r_queue [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;

    logic              w_in_accept;
    logic              w_out_accept;
    logic [LevelW-1:0] w_dwell_inc;
    logic [LevelW-1:0] w_stepped;
    t_result           w_result;

    assign o_cfg_ready  = 1'b1;
    assign o_in_stall   = (r_count == 2'd2);
    assign o_out_valid  = (r_count != 2'd0);
    assign w_in_accept  = i_in_valid & ~o_in_stall;
    assign w_out_accept = o_out_valid & ~i_out_stall;

    assign o_duty        = r_queue[r_rd_ptr].duty;
    assign o_direction   = r_queue[r_rd_ptr].direction;
    assign o_stopped     = r_queue[r_rd_ptr].stopped;
    assign o_speed_level = r_queue[r_rd_ptr].speed_level;

    // one step toward the target, held when equal
    always_comb begin
        if (r_target_level > r_ramp_level) begin
            w_stepped = r_ramp_level + 8'd1;
        end else if (r_target_level < r_ramp_level) begin
            w_stepped = r_ramp_level - 8'd1;
        end else begin
            w_stepped = r_ramp_level;
        end
    end

    assign w_dwell_inc = r_dwell_count + 8'd1;

    // next controller state for the item in flight
    always_comb begin
        n_ramp_level   = r_ramp_level;
        n_target_level = r_target_level;
        n_slot         = r_slot;
        n_dwell_count  = r_dwell_count;
        n_at_neutral   = r_at_neutral;
        n_stop_latch   = r_stop_latch;
        n_duty         = r_duty;
        n_direction    = r_direction;

        case (i_kind)
            KIND_TICK: begin
                if (r_stop_latch) begin
                    n_duty      = '0;
                    n_direction = DRIVE_OFF;
                end else begin
                    if (r_ramp_level != LevelNeutral && !r_at_neutral) begin
                        n_ramp_level = w_stepped;
                    end else if (r_ramp_level == LevelNeutral) begin
                        // dwell at neutral before crossing over
                        n_at_neutral  = 1'b1;
                        n_dwell_count = w_dwell_inc;
                        if (w_dwell_inc > r_dwell_limit) begin
                            n_ramp_level  = w_stepped;
                            n_dwell_count = '0;
                            n_at_neutral  = 1'b0;
                        end
                    end
                    // duty and direction follow the new level
                    if (n_ramp_level < LevelNeutral) begin
                        n_duty      = (LevelNeutral - n_ramp_level) << 1;
                        n_direction = DRIVE_FWD;
                    end else if (n_ramp_level > LevelNeutral) begin
                        n_duty      = (n_ramp_level - LevelBackBase) << 1;
                        n_direction = DRIVE_REV;
                    end else begin
                        n_duty      = '0;
                        n_direction = DRIVE_OFF;
                    end
                end
            end
            KIND_SAMPLE: begin
                case (r_slot)
                    SLOT_FIRST:  n_slot = SLOT_TARGET;
                    SLOT_TARGET: begin
                        n_target_level = i_sample;
                        n_slot         = SLOT_LAST;
                    end
                    SLOT_LAST:   n_slot = SLOT_FIRST;
                    default:     n_slot = r_slot;
                endcase
            end
            KIND_RX: begin
                if (i_rx_byte == r_stop_byte) begin
                    n_stop_latch = 1'b1;
                end
            end
            default: begin
                n_stop_latch = r_stop_latch;
            end
        endcase
    end

    assign w_result = '{duty: n_duty, direction: n_direction,
                        stopped: n_stop_latch, speed_level: n_ramp_level};

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dwell_limit <= DwellLimitRst;
            r_stop_byte   <= StopByteRst;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DWELL_LIMIT: r_dwell_limit <= i_cfg_data;
                CFG_STOP_BYTE:   r_stop_byte   <= i_cfg_data;
                default:         r_stop_byte   <= r_stop_byte;
            endcase
        end
    end

    // controller state, updated on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_level   <= LevelNeutral;
            r_target_level <= '0;
            r_slot         <= SLOT_FIRST;
            r_dwell_count  <= '0;
            r_at_neutral   <= 1'b0;
            r_stop_latch   <= 1'b0;
            r_duty         <= DutyReset;
            r_direction    <= DRIVE_OFF;
        end else if (w_in_accept) begin
            r_ramp_level   <= n_ramp_level;
            r_target_level <= n_target_level;
            r_slot         <= n_slot;
            r_dwell_count  <= n_dwell_count;
            r_at_neutral   <= n_at_neutral;
            r_stop_latch   <= n_stop_latch;
            r_duty         <= n_duty;
            r_direction    <= n_direction;
        end
    end

    // output queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_in_accept) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_out_accept) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_in_accept, w_out_accept})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // output queue payload
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_queue[r_wr_ptr] <= w_result;
        end
    end

`ifndef ASSERT_OFF
    // queue never holds more than two results
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("output queue count out of range");

    // emergency stop only clears through reset
    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stop_latch |=> r_stop_latch)
        else $error("stop latch cleared without reset");

    // a stopped controller never moves the level
    a_stop_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stop_latch |=> $stable(r_ramp_level))
        else $error("level moved while stopped");

    // dwell counting only happens while parked at neutral
    a_dwell_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_at_neutral |-> (r_dwell_count == '0))
        else $error("dwell count nonzero away from neutral");
`endif

endmodule

>>> verif/bidirectional_motor_ramp_pwm_test.sv
// self-checking testbench for the bidirectional motor ramp pwm block; sends ticks,
// adc samples and serial bytes, and checks each status transfer against
// a model kept here or a pinned status; depends on bmrp_pkg and the rtl top level

module bidirectional_motor_ramp_pwm_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bmrp_pkg::*;

    // kind code the block has no use for, it must leave the state alone
    localparam logic [KindW-1:0] KIND_SPARE = 2'd3;

    localparam int unsigned HoldOffCycles = 40;
    localparam int unsigned TailCycles    = 8;
    localparam int unsigned LimitNs       = 2_000_000;

    // status values that can be read straight off the rules
    localparam t_result AtReset   = {DutyReset, DRIVE_OFF, 1'b0, LevelNeutral};
    localparam t_result Parked    = {8'd0, DRIVE_OFF, 1'b0, LevelNeutral};
    localparam t_result FirstStep = {8'd2, DRIVE_FWD, 1'b0, 8'd126};
    localparam t_result Modeled   = '0;

    // one row of the directed table: an item, or a pair of register writes
    typedef struct packed {
        logic              is_cfg;
        logic [KindW-1:0]  kind;
        logic [LevelW-1:0] sample;   // dwell limit on a register row
        logic [LevelW-1:0] rx_byte;  // stop byte on a register row
        logic              pinned;   // want holds the status typed in
        t_result           want;
    } t_step_row;

    localparam int DirectedLen = 26;
    localparam t_step_row Directed [DirectedLen] = '{
        // reset settings: dwell limit 50, stop byte 32
        '{1'b0, KIND_SAMPLE, 8'd255, 8'd0,   1'b1, AtReset},   // first slot, dropped
        '{1'b0, KIND_SPARE,  8'd255, 8'd255, 1'b1, AtReset},   // unused kind
        '{1'b0, KIND_RX,     8'd0,   8'd0,   1'b1, AtReset},
        '{1'b0, KIND_RX,     8'd0,   8'd255, 1'b1, AtReset},
        '{1'b0, KIND_TICK,   8'd0,   8'd0,   1'b1, Parked},    // starts dwelling
        '{1'b0, KIND_SAMPLE, 8'd0,   8'd0,   1'b1, Parked},    // target slot, target 0
        '{1'b0, KIND_SAMPLE, 8'd128, 8'd0,   1'b1, Parked},    // last slot, dropped
        // shortest dwell, stop byte at its top
        '{1'b1, KIND_TICK,   8'd0,   8'd255, 1'b0, Modeled},
        '{1'b0, KIND_TICK,   8'd0,   8'd0,   1'b1, FirstStep}, // leaves neutral
        '{1'b0, KIND_TICK,   8'd0,   8'd0,   1'b0, Modeled},
        '{1'b0, KIND_RX,     8'd0,   8'd254, 1'b0, Modeled},
        '{1'b0, KIND_SAMPLE, 8'd7,   8'd0,   1'b0, Modeled},
        '{1'b0, KIND_SAMPLE, 8'd255, 8'd0,   1'b0, Modeled},   // turn around to full back
        '{1'b0, KIND_SAMPLE, 8'd1,   8'd0,   1'b0, Modeled},
        '{1'b0, KIND_TICK,   8'd0,   8'd0,   1'b0, Modeled},
        '{1'b0, KIND_TICK,   8'd0,   8'd0,   1'b0, Modeled},   // back at neutral
        '{1'b0, KIND_TICK,   8'd0,   8'd0,   1'b0, Modeled},   // crosses over
        '{1'b0, KIND_TICK,   8'd0,   8'd0,   1'b0, Modeled},
        // largest dwell limit, the level can never leave neutral again
        '{1'b1, KIND_TICK,   8'd255, 8'd0,   1'b0, Modeled},
        '{1'b0, KIND_RX,     8'd0,   8'd1,   1'b0, Modeled},
        '{1'b0, KIND_SAMPLE, 8'd0,   8'd0,   1'b0, Modeled},
        '{1'b0, KIND_SAMPLE, 8'd127, 8'd0,   1'b0, Modeled},
        '{1'b0, KIND_SAMPLE, 8'd64,  8'd0,   1'b0, Modeled},
        '{1'b0, KIND_TICK,   8'd0,   8'd0,   1'b0, Modeled},
        '{1'b0, KIND_TICK,   8'd0,   8'd0,   1'b0, Modeled},
        '{1'b0, KIND_TICK,   8'd0,   8'd0,   1'b0, Modeled}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [KindW-1:0]    i_kind;
    logic [LevelW-1:0]   i_sample;
    logic [LevelW-1:0]   i_rx_byte;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [LevelW-1:0]   o_duty;
    logic [DirW-1:0]     o_direction;
    logic                o_stopped;
    logic [LevelW-1:0]   o_speed_level;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CfgIdxW-1:0]  i_cfg_index;
    logic [LevelW-1:0]   i_cfg_data;

    // status transfers still owed by the block, oldest first
    t_result expected_status [$];
    int unsigned fail_count = 0;

    // pacing shared by the item feeder and the status sink
    int unsigned feed_pause_pct = 0;
    int unsigned sink_pause_pct = 0;
    logic        steady_pacing  = 1'b0;
    logic        hold_off_req   = 1'b0;
    int unsigned sink_hold      = 0;

    // controller copy, starts from the reset state
    logic [LevelW-1:0] ramp        = LevelNeutral;
    logic [LevelW-1:0] target      = '0;
    logic [SlotW-1:0]  adc_slot    = SLOT_FIRST;
    logic [LevelW-1:0] dwell_ticks = '0;
    logic              parked      = 1'b0;
    logic              estop       = 1'b0;
    logic [LevelW-1:0] duty_now    = DutyReset;
    logic [DirW-1:0]   dir_now     = DRIVE_OFF;
    logic [LevelW-1:0] dwell_lim   = DwellLimitRst;
    logic [LevelW-1:0] stop_code   = StopByteRst;

    bidirectional_motor_ramp_pwm dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_sample      (i_sample),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_duty        (o_duty),
        .o_direction   (o_direction),
        .o_stopped     (o_stopped),
        .o_speed_level (o_speed_level),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // one step of the ramp toward the target
    function automatic void nudge_ramp();
        if (target > ramp) begin
            ramp = ramp + 1'b1;
        end else if (target < ramp) begin
            ramp = ramp - 1'b1;
        end
    endfunction

    // applies one item to the controller copy and returns the status after it
    function automatic t_result advance_motor(input logic [KindW-1:0] kind,
                                              input logic [LevelW-1:0] sample,
                                              input logic [LevelW-1:0] rx);
        case (kind)
            KIND_TICK: begin
                if (estop) begin
                    // stopped: output off, level frozen
                    duty_now = '0;
                    dir_now  = DRIVE_OFF;
                end else begin
                    if (ramp != LevelNeutral && !parked) begin
                        nudge_ramp();
                    end else if (ramp == LevelNeutral) begin
                        // dwell at neutral, count wraps in 8 bits
                        parked      = 1'b1;
                        dwell_ticks = dwell_ticks + 1'b1;
                        if (dwell_ticks > dwell_lim) begin
                            nudge_ramp();
                            dwell_ticks = '0;
                            parked      = 1'b0;
                        end
                    end
                    if (ramp < LevelNeutral) begin
                        duty_now = (LevelNeutral - ramp) << 1;
                        dir_now  = DRIVE_FWD;
                    end else if (ramp > LevelNeutral) begin
                        duty_now = (ramp - LevelBackBase) << 1;
                        dir_now  = DRIVE_REV;
                    end else begin
                        duty_now = '0;
                        dir_now  = DRIVE_OFF;
                    end
                end
            end
            KIND_SAMPLE: begin
                // only the middle slot of the sequence sets the target
                case (adc_slot)
                    SLOT_FIRST:  adc_slot = SLOT_TARGET;
                    SLOT_TARGET: begin
                        target   = sample;
                        adc_slot = SLOT_LAST;
                    end
                    SLOT_LAST:   adc_slot = SLOT_FIRST;
                    default:     ;
                endcase
            end
            KIND_RX: begin
                if (rx == stop_code) begin
                    estop = 1'b1;
                end
            end
            default: ;
        endcase
        return {duty_now, dir_now, estop, ramp};
    endfunction

    // offers one item and holds it until the transfer; stall is judged at the
    // falling edge, where everything driven at the rising edge has settled
    task automatic offer(input logic [KindW-1:0] kind, input logic [LevelW-1:0] sample,
                         input logic [LevelW-1:0] rx, input logic pinned,
                         input t_result pinned_want);
        logic    taken;
        t_result forecast;
        if (feed_pause_pct != 0 && $urandom_range(0, 99) < feed_pause_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_sample   <= sample;
        i_rx_byte  <= rx;
        do begin
            @(negedge i_clk);
            taken = (o_in_stall === 1'b0);
            if (taken) begin
                forecast = advance_motor(kind, sample, rx);
                expected_status.push_back(pinned ? pinned_want : forecast);
            end
            @(posedge i_clk);
        end while (!taken);
    endtask

    // stops feeding and waits until every owed status has been taken
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_status.size() != 0) @(posedge i_clk);
    endtask

    // writes both registers back to back; the block must be idle
    task automatic set_regs(input logic [LevelW-1:0] dwell, input logic [LevelW-1:0] stop);
        logic done;
        for (int r = 0; r < 2; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= (r == 0) ? CFG_DWELL_LIMIT : CFG_STOP_BYTE;
            i_cfg_data  <= (r == 0) ? dwell : stop;
            do begin
                @(negedge i_clk);
                done = (o_cfg_ready === 1'b1);
                if (done && r == 0) begin
                    dwell_lim = dwell;
                end else if (done) begin
                    stop_code = stop;
                end
                @(posedge i_clk);
            end while (!done);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // random items: ticks at the given share, the rest mostly adc samples
    task automatic run_random(input int unsigned count, input int unsigned tick_pct);
        logic [KindW-1:0]  kind;
        logic [LevelW-1:0] sample;
        logic [LevelW-1:0] rx;
        int unsigned       roll;
        for (int unsigned i = 0; i < count; i++) begin
            // pacing changes now and then, zero included for gap-free stretches
            if (!steady_pacing && i % 40 == 0) begin
                feed_pause_pct = 15 * $urandom_range(0, 2);
                sink_pause_pct = 15 * $urandom_range(0, 2);
            end
            sample = LevelW'($urandom);
            rx     = LevelW'($urandom);
            roll   = $urandom_range(0, 99);
            if (roll < tick_pct) begin
                kind = KIND_TICK;
            end else begin
                roll = $urandom_range(0, 19);
                kind = (roll == 0) ? KIND_SPARE : (roll < 3) ? KIND_RX : KIND_SAMPLE;
            end
            // targets lean toward full scale and neutral so the ramp reaches its ends
            case ($urandom_range(0, 7))
                0:       sample = '0;
                1:       sample = '1;
                2:       sample = LevelNeutral;
                default: ;
            endcase
            // the stop latches for good, so it is saved for the last phase
            while (rx == stop_code) rx = LevelW'($urandom);
            offer(kind, sample, rx, 1'b0, Modeled);
        end
    endtask

    // status sink: random stall bursts, or one long hold-off on request
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1) begin
            sink_hold = 0;
            i_out_stall <= 1'b0;
        end else begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                sink_hold    = HoldOffCycles;
            end else if (sink_hold == 0 && sink_pause_pct != 0
                         && $urandom_range(0, 99) < sink_pause_pct) begin
                sink_hold = $urandom_range(1, 13);
            end
            if (sink_hold != 0) begin
                i_out_stall <= 1'b1;
                sink_hold    = sink_hold - 1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // status check: a transfer happens at the next rising edge, so the values
    // seen at the falling edge are the ones that move
    always @(negedge i_clk) begin : status_check
        t_result seen;
        t_result want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            seen = {o_duty, o_direction, o_stopped, o_speed_level};
            if (expected_status.size() == 0) begin
                $display("%0t: status with none owed, duty %0d dir %0d stopped %0d level %0d",
                         $time, seen.duty, seen.direction, seen.stopped, seen.speed_level);
                fail_count++;
            end else begin
                want = expected_status.pop_front();
                if (seen !== want) begin
                    $display("%0t: expected duty %0d dir %0d stopped %0d level %0d",
                             $time, want.duty, want.direction, want.stopped,
                             want.speed_level);
                    $display("%0t:   actual duty %0d dir %0d stopped %0d level %0d",
                             $time, seen.duty, seen.direction, seen.stopped,
                             seen.speed_level);
                    fail_count++;
                end
            end
        end
    end

    initial begin : stimulus
        logic [LevelW-1:0] final_stop;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_kind      = KIND_TICK;
        i_sample    = '0;
        i_rx_byte   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_DWELL_LIMIT;
        i_cfg_data  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table under light pacing
        feed_pause_pct = 15;
        sink_pause_pct = 15;
        for (int i = 0; i < DirectedLen; i++) begin
            if (Directed[i].is_cfg) begin
                settle();
                set_regs(Directed[i].sample, Directed[i].rx_byte);
            end else begin
                offer(Directed[i].kind, Directed[i].sample, Directed[i].rx_byte,
                      Directed[i].pinned, Directed[i].want);
            end
        end

        // short dwell: the level swings across neutral often
        settle();
        set_regs(8'd1, 8'd32);
        run_random(70, 50);

        // longest dwell that still lets the level cross, nearly all ticks
        settle();
        set_regs(8'd254, 8'd200);
        run_random(140, 95);

        // no dwell at all
        settle();
        set_regs(8'd0, 8'd77);
        run_random(60, 60);

        // sink holds off for a long stretch while items keep coming, so the
        // output queue fills and the input stalls
        settle();
        set_regs(8'd3, 8'd12);
        steady_pacing  = 1'b1;
        feed_pause_pct = 0;
        sink_pause_pct = 0;
        hold_off_req   = 1'b1;
        run_random(30, 50);
        // feeder waits for every owed status before going on
        settle();
        steady_pacing = 1'b0;
        run_random(30, 50);

        // last phase without idling: latch the stop and keep ticking
        settle();
        final_stop = LevelW'($urandom);
        set_regs(8'd2, final_stop);
        steady_pacing  = 1'b1;
        feed_pause_pct = 0;
        sink_pause_pct = 0;
        run_random(25, 50);
        offer(KIND_RX, LevelW'($urandom), final_stop, 1'b0, Modeled);
        run_random(25, 50);

        settle();
        repeat (TailCycles) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[bidirectional_motor_ramp_pwm] OK");
        end else begin
            $display("[bidirectional_motor_ramp_pwm] ERROR");
        end
        $finish;
    end

    // hard limit on run time
    initial begin : watchdog
        #(LimitNs);
        $display("[bidirectional_motor_ramp_pwm] ERROR");
        $finish;
    end

endmodule
